FILE: rtl/core/sawarq_pkg.sv
`default_nettype none
package sawarq_pkg;

  localparam int PAYLOAD_DEPTH = 2048;
  localparam int HDR_BYTES     = 10;
  localparam int LIMIT_W       = 12;
  localparam int LIMIT_RESET   = 1490;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  // counts up to the header plus a full payload
  localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + HDR_BYTES + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_RESP = 2'd1,
    REQ_SLOT = 2'd2,
    REQ_SOF  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ACKED   = 3'd1,
    ST_RESEND  = 3'd2,
    ST_IGNORED = 3'd3,
    ST_REJECT  = 3'd4,
    ST_NOTHING = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_COLLECT = 3'b001,
    PH_SEND    = 3'b010,
    PH_WAIT    = 3'b100
  } phase_t;

  // ones'-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[16]) begin
      s = {1'b0, s[15:0]} + 17'd1;
    end
    return s[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/stop_and_wait_arq_sender_core.sv
// Stop-and-wait ARQ sender, byte serial.
// Input stream: one request per transfer. in_tuser selects the request
// (payload byte, receiver response, send slot, start of file), in_tlast marks
// the final file byte, in_tdata carries data byte, echoed sequence and ACK flag.
// Output stream: exactly one result per request. out_tdata is the packet byte,
// out_tuser holds the byte-valid flag and a status code, out_tlast marks the
// final byte of a packet. Each send slot yields one byte: 10 header bytes
// (seq, next seq, flags, length, checksum) then the payload.
// The cfg channel writes the payload limit; it is always ready and is meant to
// be used only while no request is in flight.
// The result of a request appears in the cycle after its transfer, from the
// output register. Throughput: one request per cycle while results are taken;
// payload bytes come from a single-port-read payload memory with a registered read.
// When the receiver stalls the result holds and in_tready drops until the
// output register is taken.
// Reset (synchronous, rst_n low) clears sequence, counters, the phase and sets
// the limit to 1490; payload memory contents are not cleared.
`default_nettype none
module stop_and_wait_arq_sender_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // data_byte[7:0], resp_seq[23:8], resp_flag[31:24]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  input  wire logic        in_tlast,   // end_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // tx_byte[7:0]
  output logic [3:0]       out_tuser,  // tx_valid[0], status[3:1]
  output logic             out_tlast,  // tx_last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [sawarq_pkg::LIMIT_W-1:0] cfg_data
);

  logic [7:0] mem [sawarq_pkg::PAYLOAD_DEPTH];

  logic [sawarq_pkg::LIMIT_W-1:0] limit_r;
  sawarq_pkg::cnt_t   fill_r, fill_nxt;
  sawarq_pkg::cnt_t   emit_r, emit_nxt;
  logic [15:0]        seq_r, seq_nxt;
  logic [15:0]        sum_r, sum_nxt;
  logic               final_r, final_nxt;
  sawarq_pkg::phase_t phase_r, phase_nxt;

  logic               ov_r;
  logic               txv_r, txv_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               last_r, last_nxt;
  sawarq_pkg::status_t status_r, status_nxt;
  logic               use_mem_r, use_mem_nxt;
  logic [7:0]         rd_r;

  logic               acc;
  logic               wr_en;
  logic               rd_en;
  sawarq_pkg::addr_t  rd_addr;
  sawarq_pkg::req_t   req;
  logic [7:0]         in_byte;
  logic [15:0]        in_seq;
  logic [7:0]         in_flag;
  sawarq_pkg::cnt_t   lim_eff;
  sawarq_pkg::cnt_t   fill_inc;
  sawarq_pkg::cnt_t   emit_inc;
  logic [15:0]        next_seq;
  logic [15:0]        csum;
  logic [15:0]        hdr_word;
  logic [7:0]         hdr_byte;

  assign cfg_ready = 1'b1;
  assign in_tready = !ov_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign req       = sawarq_pkg::req_t'(in_tuser);
  assign in_byte   = in_tdata[7:0];
  assign in_seq    = in_tdata[23:8];
  assign in_flag   = in_tdata[31:24];

  assign fill_inc  = fill_r + sawarq_pkg::cnt_t'(1);
  assign emit_inc  = emit_r + sawarq_pkg::cnt_t'(1);
  assign next_seq  = final_r ? 16'd0 : seq_r + 16'd1;
  assign csum      = ~sawarq_pkg::oc_add(sawarq_pkg::oc_add(sawarq_pkg::oc_add(sum_r, seq_r),
                                                            next_seq), 16'(fill_r));

  always_comb begin
    if (limit_r == '0) begin
      lim_eff = sawarq_pkg::cnt_t'(1);
    end else if (32'(limit_r) > sawarq_pkg::PAYLOAD_DEPTH) begin
      lim_eff = sawarq_pkg::cnt_t'(sawarq_pkg::PAYLOAD_DEPTH);
    end else begin
      lim_eff = sawarq_pkg::cnt_t'(limit_r);
    end
  end

  always_comb begin
    case (emit_r[3:1])
      3'd0:    hdr_word = seq_r;
      3'd1:    hdr_word = next_seq;
      3'd2:    hdr_word = 16'd0;
      3'd3:    hdr_word = 16'(fill_r);
      default: hdr_word = csum;
    endcase
    hdr_byte = emit_r[0] ? hdr_word[7:0] : hdr_word[15:8];
  end

  always_comb begin
    fill_nxt    = fill_r;
    emit_nxt    = emit_r;
    seq_nxt     = seq_r;
    sum_nxt     = sum_r;
    final_nxt   = final_r;
    phase_nxt   = phase_r;
    txv_nxt     = 1'b0;
    byte_nxt    = 8'd0;
    last_nxt    = 1'b0;
    status_nxt  = sawarq_pkg::ST_OK;
    use_mem_nxt = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = sawarq_pkg::addr_t'(emit_r - sawarq_pkg::cnt_t'(sawarq_pkg::HDR_BYTES));
    if (acc) begin
      unique case (req)
        sawarq_pkg::REQ_SOF: begin
          seq_nxt   = 16'd0;
          fill_nxt  = '0;
          emit_nxt  = '0;
          sum_nxt   = 16'd0;
          final_nxt = 1'b0;
          phase_nxt = sawarq_pkg::PH_COLLECT;
        end
        sawarq_pkg::REQ_BYTE: begin
          if (phase_r != sawarq_pkg::PH_COLLECT ||
              32'(fill_r) >= sawarq_pkg::PAYLOAD_DEPTH) begin
            status_nxt = sawarq_pkg::ST_REJECT;
          end else begin
            wr_en    = 1'b1;
            sum_nxt  = sawarq_pkg::oc_add(sum_r, fill_r[0] ? {8'd0, in_byte} : {in_byte, 8'd0});
            fill_nxt = fill_inc;
            if (in_tlast || fill_inc >= lim_eff) begin
              final_nxt = in_tlast;
              emit_nxt  = '0;
              phase_nxt = sawarq_pkg::PH_SEND;
            end
          end
        end
        sawarq_pkg::REQ_SLOT: begin
          if (phase_r != sawarq_pkg::PH_SEND) begin
            status_nxt = sawarq_pkg::ST_NOTHING;
          end else begin
            txv_nxt = 1'b1;
            if (32'(emit_r) < sawarq_pkg::HDR_BYTES) begin
              byte_nxt = hdr_byte;
            end else begin
              use_mem_nxt = 1'b1;
              rd_en       = 1'b1;
            end
            emit_nxt = emit_inc;
            if (emit_inc >= fill_r + sawarq_pkg::cnt_t'(sawarq_pkg::HDR_BYTES)) begin
              last_nxt  = 1'b1;
              phase_nxt = sawarq_pkg::PH_WAIT;
            end
          end
        end
        sawarq_pkg::REQ_RESP: begin
          if (phase_r != sawarq_pkg::PH_WAIT || in_seq != seq_r) begin
            status_nxt = sawarq_pkg::ST_IGNORED;
          end else if (in_flag == 8'd1) begin
            seq_nxt    = seq_r + 16'd1;
            fill_nxt   = '0;
            emit_nxt   = '0;
            sum_nxt    = 16'd0;
            final_nxt  = 1'b0;
            phase_nxt  = sawarq_pkg::PH_COLLECT;
            status_nxt = sawarq_pkg::ST_ACKED;
          end else begin
            emit_nxt   = '0;
            phase_nxt  = sawarq_pkg::PH_SEND;
            status_nxt = sawarq_pkg::ST_RESEND;
          end
        end
      endcase
    end
  end

  // writes happen only while collecting, reads only while sending, and the
  // first payload read trails the last write by the header, so no bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sawarq_pkg::addr_t'(fill_r)] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sawarq_pkg::LIMIT_W'(sawarq_pkg::LIMIT_RESET);
      fill_r  <= '0;
      emit_r  <= '0;
      seq_r   <= 16'd0;
      sum_r   <= 16'd0;
      final_r <= 1'b0;
      phase_r <= sawarq_pkg::PH_COLLECT;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      fill_r  <= fill_nxt;
      emit_r  <= emit_nxt;
      seq_r   <= seq_nxt;
      sum_r   <= sum_nxt;
      final_r <= final_nxt;
      phase_r <= phase_nxt;
      if (in_tready) begin
        ov_r <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      txv_r     <= txv_nxt;
      byte_r    <= byte_nxt;
      last_r    <= last_nxt;
      status_r  <= status_nxt;
      use_mem_r <= use_mem_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = use_mem_r ? rd_r : byte_r;
  assign out_tuser  = {status_r, txv_r};
  assign out_tlast  = last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= sawarq_pkg::PAYLOAD_DEPTH)
    else $error("fill count beyond payload depth");

  a_write_collect: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> phase_r == sawarq_pkg::PH_COLLECT)
    else $error("payload write outside collecting phase");

  a_last_wait: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last_nxt |=> phase_r == sawarq_pkg::PH_WAIT && out_tvalid && out_tlast)
    else $error("last packet byte did not move to awaiting response");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[3:1] == sawarq_pkg::ST_OK)
    else $error("packet byte with non-ok status");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sawarq_pkg::PH_SEND |->
      emit_r < fill_r + sawarq_pkg::cnt_t'(sawarq_pkg::HDR_BYTES))
    else $error("emit pointer past end of packet while sending");

endmodule
`default_nettype wire

FILE: bench/stop_and_wait_arq_sender_core_test.sv
`timescale 1ns / 100ps
module stop_and_wait_arq_sender_core_test;

  localparam int WD_LIMIT = 2000;
  localparam logic [sawarq_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef struct packed {
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic                tx_last;
    sawarq_pkg::status_t status;
  } tx_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata = '0;   // data_byte[7:0], resp_seq[23:8], resp_flag[31:24]
  logic [1:0]         in_tuser = '0;   // req_type[1:0]
  logic               in_tlast = 1'b0; // end_of_file
  logic               out_tvalid;
  logic               out_tready = 1'b1;
  logic [7:0]         out_tdata;       // tx_byte[7:0]
  logic [3:0]         out_tuser;       // tx_valid[0], status[3:1]
  logic               out_tlast;       // tx_last
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [sawarq_pkg::LIMIT_W-1:0] cfg_data = '0;

  stop_and_wait_arq_sender_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // sender model state
  logic [sawarq_pkg::LIMIT_W-1:0] m_limit;
  logic [7:0]         m_store [sawarq_pkg::PAYLOAD_DEPTH];
  int                 m_fill;
  int                 m_emit;
  logic [15:0]        m_seq;
  logic [15:0]        m_psum;
  logic               m_final;
  sawarq_pkg::phase_t m_phase;

  tx_result_t pending_tx[$];
  int idle_pct;
  int stall_pct;
  int n_err;
  int n_reqs;
  int n_acked;
  int n_resends;
  int n_cfg;

  function automatic logic [15:0] ones_sum16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic logic [15:0] next_seq_word();
    return m_final ? 16'd0 : m_seq + 16'd1;
  endfunction

  function automatic logic [7:0] header_byte(input int k);
    logic [15:0] w;
    case (k / 2)
      0: w = m_seq;
      1: w = next_seq_word();
      2: w = 16'd0;
      3: w = 16'(m_fill);
      default: w = ~ones_sum16(ones_sum16(ones_sum16(m_psum, m_seq), next_seq_word()),
                               16'(m_fill));
    endcase
    return (k % 2 == 1) ? w[7:0] : w[15:8];
  endfunction

  function automatic void clear_packet();
    m_fill  = 0;
    m_emit  = 0;
    m_psum  = '0;
    m_final = 1'b0;
    m_phase = sawarq_pkg::PH_COLLECT;
  endfunction

  function automatic tx_result_t arq_predict(input sawarq_pkg::req_t req,
                                             input logic [7:0] d,
                                             input logic eof, input logic [15:0] rseq,
                                             input logic [7:0] rflag);
    tx_result_t r;
    int eff;
    r = '{1'b0, 8'h00, 1'b0, sawarq_pkg::ST_OK};
    case (req)
      sawarq_pkg::REQ_SOF: begin
        m_seq = '0;
        clear_packet();
      end
      sawarq_pkg::REQ_BYTE: begin
        if (m_phase != sawarq_pkg::PH_COLLECT || m_fill >= sawarq_pkg::PAYLOAD_DEPTH) begin
          r.status = sawarq_pkg::ST_REJECT;
        end else begin
          m_store[m_fill] = d;
          m_psum = ones_sum16(m_psum, (m_fill % 2 == 1) ? {8'h00, d} : {d, 8'h00});
          m_fill++;
          eff = (m_limit == 0) ? 1 :
                (m_limit > sawarq_pkg::PAYLOAD_DEPTH) ? sawarq_pkg::PAYLOAD_DEPTH :
                int'(m_limit);
          if (eof || m_fill >= eff) begin
            m_final = eof;
            m_emit  = 0;
            m_phase = sawarq_pkg::PH_SEND;
          end
        end
      end
      sawarq_pkg::REQ_SLOT: begin
        if (m_phase != sawarq_pkg::PH_SEND) begin
          r.status = sawarq_pkg::ST_NOTHING;
        end else begin
          r.tx_valid = 1'b1;
          r.tx_byte  = (m_emit < sawarq_pkg::HDR_BYTES) ? header_byte(m_emit) :
                       m_store[m_emit - sawarq_pkg::HDR_BYTES];
          m_emit++;
          if (m_emit >= sawarq_pkg::HDR_BYTES + m_fill) begin
            r.tx_last = 1'b1;
            m_phase   = sawarq_pkg::PH_WAIT;
          end
        end
      end
      default: begin
        if (m_phase != sawarq_pkg::PH_WAIT || rseq != m_seq) begin
          r.status = sawarq_pkg::ST_IGNORED;
        end else if (rflag == 8'd1) begin
          m_seq = m_seq + 16'd1;
          clear_packet();
          r.status = sawarq_pkg::ST_ACKED;
          n_acked++;
        end else begin
          m_emit   = 0;
          m_phase  = sawarq_pkg::PH_SEND;
          r.status = sawarq_pkg::ST_RESEND;
          n_resends++;
        end
      end
    endcase
    return r;
  endfunction

  // random receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_tx
    tx_result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tx.size() == 0) begin
        $error("result transfer with nothing pending");
        n_err++;
      end else begin
        exp = pending_tx.pop_front();
        if (out_tuser[0] !== exp.tx_valid) begin
          $error("tx_valid: expected %0d, got %0d", exp.tx_valid, out_tuser[0]);
          n_err++;
        end
        if (out_tdata !== exp.tx_byte) begin
          $error("tx_byte: expected %h, got %h", exp.tx_byte, out_tdata);
          n_err++;
        end
        if (out_tlast !== exp.tx_last) begin
          $error("tx_last: expected %0d, got %0d", exp.tx_last, out_tlast);
          n_err++;
        end
        if (out_tuser[3:1] !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, out_tuser[3:1]);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WD_LIMIT) begin
        $error("no transfer for %0d cycles", WD_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // leaves in_tvalid high so back-to-back requests need no bubble
  task automatic send_req(input sawarq_pkg::req_t req, input logic [7:0] d, input logic eof,
                          input logic [15:0] rseq, input logic [7:0] rflag);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {rflag, rseq, d};
    in_tlast  = eof;
    do @(posedge clk); while (!in_tready);
    pending_tx.push_back(arq_predict(req, d, eof, rseq, rflag));
    n_reqs++;
    @(negedge clk);
  endtask

  task automatic put_byte(input logic [7:0] d, input logic eof);
    send_req(sawarq_pkg::REQ_BYTE, d, eof, 16'($urandom), 8'($urandom));
  endtask

  task automatic put_slot();
    send_req(sawarq_pkg::REQ_SLOT, 8'($urandom), 1'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic put_resp(input logic [15:0] rseq, input logic [7:0] rflag);
    send_req(sawarq_pkg::REQ_RESP, 8'($urandom), 1'($urandom), rseq, rflag);
  endtask

  task automatic put_sof();
    send_req(sawarq_pkg::REQ_SOF, 8'($urandom), 1'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic emit_packet();
    while (m_phase == sawarq_pkg::PH_SEND) put_slot();
  endtask

  task automatic run_packet(input int n_bytes, input bit eof_last);
    for (int i = 0; i < n_bytes && m_phase == sawarq_pkg::PH_COLLECT; i++)
      put_byte(8'($urandom), eof_last && i == n_bytes - 1);
    emit_packet();
    put_resp(m_seq, 8'd1);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_tx.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(input logic [sawarq_pkg::LIMIT_W-1:0] v);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    m_limit = v;
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_wrong_phase_requests();
    put_slot();                       // nothing to send yet
    put_resp(16'h0000, 8'h01);        // no packet out, ignored
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hA5, 1'b1);            // odd-length final packet
    put_byte(8'hFF, 1'b0);            // dropped while sending
    put_resp(16'h0000, 8'h01);        // ignored while sending
    emit_packet();
    put_slot();
    put_byte(8'h3C, 1'b0);            // dropped while awaiting response
  endtask

  task automatic test_resend_and_ack();
    put_resp(16'hFFFF, 8'h01);        // sequence mismatch
    put_resp(m_seq, 8'h00);           // negative, resend same packet
    emit_packet();
    put_resp(m_seq, 8'h01);           // final packet acked, seq keeps counting
    run_packet(2, 1'b1);
  endtask

  task automatic test_start_of_file_abort();
    write_limit(12'd2);
    put_byte(8'h5A, 1'b0);
    put_byte(8'hC3, 1'b0);            // limit closes the packet
    put_slot();
    put_slot();
    put_sof();                        // abandon mid-packet
    put_slot();
    run_packet(2, 1'b0);
  endtask

  task automatic test_limit_extremes();
    write_limit(12'd0);               // acts as one byte
    run_packet(3, 1'b0);
    write_limit(12'd1);
    run_packet(3, 1'b0);
    write_limit(12'(sawarq_pkg::PAYLOAD_DEPTH));
    run_packet(5, 1'b1);
    write_limit(LIMIT_MAX);           // clipped to the buffer depth
    run_packet(6, 1'b1);
    write_limit(12'(sawarq_pkg::LIMIT_RESET));
    run_packet(4, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle_in, input int stall_out, input int n_items);
    int roll;
    idle_pct  = idle_in;
    stall_pct = stall_out;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        roll = $urandom_range(9);
        if (roll < 7)
          write_limit(12'($urandom_range(1, 16)));
        else if (roll < 9)
          write_limit(12'($urandom_range(17, 64)));
        else
          write_limit(12'($urandom));
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
        put_sof();
      end else if (roll < 12) begin
        send_req(sawarq_pkg::req_t'(2'($urandom)), 8'($urandom), 1'($urandom),
                 16'($urandom), 8'($urandom));
      end else begin
        case (m_phase)
          sawarq_pkg::PH_COLLECT: put_byte(8'($urandom), $urandom_range(7) == 0);
          sawarq_pkg::PH_SEND:    put_slot();
          default: begin
            if (roll < 20)
              put_resp(16'($urandom), 8'($urandom));
            else
              put_resp(m_seq, ($urandom_range(3) != 0) ? 8'd1 : 8'($urandom));
          end
        endcase
      end
    end
  endtask

  initial begin
    idle_pct  = 0;
    stall_pct = 0;
    m_limit   = 12'(sawarq_pkg::LIMIT_RESET);
    m_seq     = '0;
    clear_packet();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_wrong_phase_requests();
    test_resend_and_ack();
    test_start_of_file_abort();
    test_limit_extremes();
    test_random_traffic(0, 0, 300);
    test_random_traffic(74, 0, 300);
    test_random_traffic(0, 74, 300);
    test_random_traffic(37, 37, 300);

    wait_idle();
    repeat (5) @(negedge clk);
    $display("%0d requests, %0d packets acked, %0d resends, %0d limit writes",
             n_reqs, n_acked, n_resends, n_cfg);
    $display("idle mixes: none, sender 74%%, receiver 74%%, both 37%%");
    if (n_err == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
